FILE: design/wpc_pkg.sv
// ----------------------------------------------------------------------------
// Weighted predicate pair counter package
// Shared constants, operation codes, register indexes and control structs.
// ----------------------------------------------------------------------------
package wpc_pkg;

  localparam int SUM_W      = 40;  // Q32.8 accumulator width
  localparam int VAL_W      = 16;  // Q8.8 feature value and weight width
  localparam int FEAT_REG_W = 4;   // width of a predicate feature register
  localparam int PRED_REGS  = 4;   // predicate register sets in the register map
  localparam int CLS_MAX_W  = 4;   // class select width for up to sixteen classes
  localparam int SLOT_MAX_W = 4;   // sum slot select width for up to sixteen sums
  localparam int CFG_IDX_W  = 3;

  // Item operations, carried in tuser.
  localparam logic [1:0] FUNC_WRITE_FEATURE = 2'd0;
  localparam logic [1:0] FUNC_ADD_WEIGHT    = 2'd1;
  localparam logic [1:0] FUNC_READ_SUM      = 2'd2;
  localparam logic [1:0] FUNC_CLEAR_SUMS    = 2'd3;

  // Read selections.
  localparam logic [1:0] READ_CLASS_TOTAL = 2'd0;
  localparam logic [1:0] READ_SINGLE_SUM  = 2'd1;
  localparam logic [1:0] READ_PAIR_SUM    = 2'd2;

  // Register map: four feature selects, then four thresholds.
  localparam logic [CFG_IDX_W-1:0] CFG_PRED0_FEATURE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRED3_FEATURE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRED0_THRESHOLD = 3'd4;

  // Feature select change, forwarded to the feature store.
  typedef struct packed {
    logic                  we;
    logic [1:0]            pred;
    logic [FEAT_REG_W-1:0] feat;
  } cfg_feat_t;

  // Accumulate or clear request for the sum bank.
  typedef struct packed {
    logic                   add;
    logic                   clr;
    logic [CLS_MAX_W-1:0]   cls;
    logic signed [VAL_W-1:0] weight;
    logic [PRED_REGS-1:0]   hits;
  } accum_op_t;

  // Sum read selection.
  typedef struct packed {
    logic                  valid;
    logic [CLS_MAX_W-1:0]  cls;
    logic [SLOT_MAX_W-1:0] slot;
  } sum_sel_t;

  // Position of pair (i, j), i <= j, among the pair sums.
  function automatic int pair_slot(input int i, input int j, input int np);
    return i * np - ((i * (i - 1)) >> 1) + (j - i);
  endfunction

endpackage

FILE: design/weighted_predicate_pair_counter.sv
// ----------------------------------------------------------------------------
// Weighted predicate pair counter
// Weighted support counting of threshold predicates and predicate pairs.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the output side is not
// stalled and returns exactly one result transaction for each, in order: the
// transaction is held in the input register and then makes one pass through
// the 40-bit saturating adders of the selected class into the result
// register. All sums of a class (the total, one per predicate and one per
// predicate pair) update in parallel in that single pass, which sets the
// rate. A feature select write refreshes the tracked feature of its
// predicate from the row memory in the cycle after the write.
module weighted_predicate_pair_counter #(
  parameter int NUM_FEATURES   = 16,
  parameter int NUM_PREDICATES = 4,
  parameter int NUM_CLASSES    = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [wpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wpc_pkg::VAL_W-1:0]         cfg_wdata_i,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // feature_index[3:0], sample_value[19:4], class_index[21:20],
  // read_kind[23:22], pred_first[25:24], pred_second[27:26], zero pad[31:28]
  input  logic [31:0]                       s_axis_tdata,
  // func[1:0]
  input  logic [1:0]                        s_axis_tuser,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // sum_value[39:0], predicate_hits[43:40], zero pad[47:44]
  output logic [47:0]                       m_axis_tdata,
  // saturated
  output logic                              m_axis_tuser
);
  import wpc_pkg::*;

  // Configuration registers.
  logic [PRED_REGS-1:0][FEAT_REG_W-1:0] pred_feat_q;
  logic signed [VAL_W-1:0]              pred_thr_q [PRED_REGS];
  cfg_feat_t                            cfg_feat;

  // Input register.
  logic                    in_valid_q;
  logic [1:0]              in_func_q;
  logic [FEAT_REG_W-1:0]   in_fidx_q;
  logic signed [VAL_W-1:0] in_val_q;
  logic [1:0]              in_cls_q;
  logic [1:0]              in_kind_q;
  logic [1:0]              in_pa_q;
  logic [1:0]              in_pb_q;

  // Result register.
  logic                    out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0] out_sum_q, out_sum_d;
  logic [PRED_REGS-1:0]    out_hits_q, out_hits_d;
  logic                    out_sat_q, out_sat_d;

  logic                    in_accept, advance, cls_ok;
  logic signed [VAL_W-1:0] pred_val [NUM_PREDICATES];
  logic [NUM_PREDICATES-1:0] pred_ok;
  logic [PRED_REGS-1:0]    hits;
  logic [1:0]              pair_lo, pair_hi;
  accum_op_t               accum_op;
  sum_sel_t                sum_sel;
  logic                    add_clip, rd_mark;
  logic signed [SUM_W-1:0] rd_sum;

  // The item in the input register completes when the result register is
  // free or is being emptied in the same cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_func_q <= s_axis_tuser;
      in_fidx_q <= s_axis_tdata[3:0];
      in_val_q  <= s_axis_tdata[19:4];
      in_cls_q  <= s_axis_tdata[21:20];
      in_kind_q <= s_axis_tdata[23:22];
      in_pa_q   <= s_axis_tdata[25:24];
      in_pb_q   <= s_axis_tdata[27:26];
    end
  end

  // Configuration writes; index values past the thresholds are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PRED_REGS; p++) begin
        pred_feat_q[p] <= '0;
        pred_thr_q[p]  <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i < CFG_PRED0_THRESHOLD) begin
        pred_feat_q[cfg_idx_i[1:0]] <= cfg_wdata_i[FEAT_REG_W-1:0];
      end else begin
        pred_thr_q[cfg_idx_i[1:0]] <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    cfg_feat.we   = cfg_we_i && (cfg_idx_i >= CFG_PRED0_FEATURE) &&
                    (cfg_idx_i <= CFG_PRED3_FEATURE);
    cfg_feat.pred = cfg_idx_i[1:0];
    cfg_feat.feat = cfg_wdata_i[FEAT_REG_W-1:0];
  end

  wpc_feature_store #(
    .NUM_FEATURES   (NUM_FEATURES),
    .NUM_PREDICATES (NUM_PREDICATES)
  ) u_feature_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_feat_i  (cfg_feat),
    .pred_feat_i (pred_feat_q),
    .wr_en_i     (advance && (in_func_q == FUNC_WRITE_FEATURE)),
    .wr_idx_i    (in_fidx_q),
    .wr_val_i    (in_val_q),
    .pred_val_o  (pred_val),
    .pred_ok_o   (pred_ok)
  );

  // A predicate holds when its tracked feature is strictly above its
  // threshold; predicates that the build leaves out never hold.
  always_comb begin
    hits = '0;
    for (int p = 0; p < NUM_PREDICATES; p++) begin
      hits[p] = pred_ok[p] && (pred_val[p] > pred_thr_q[p]);
    end
  end

  assign cls_ok = 32'(in_cls_q) < NUM_CLASSES;

  always_comb begin
    accum_op.add    = advance && (in_func_q == FUNC_ADD_WEIGHT) && cls_ok;
    accum_op.clr    = advance && (in_func_q == FUNC_CLEAR_SUMS);
    accum_op.cls    = {{(CLS_MAX_W-2){1'b0}}, in_cls_q};
    accum_op.weight = in_val_q;
    accum_op.hits   = hits;
  end

  // Read selection. A pair read is taken in (min, max) order; a predicate
  // index outside the build or an undefined read kind selects nothing.
  always_comb begin
    pair_lo       = (in_pa_q < in_pb_q) ? in_pa_q : in_pb_q;
    pair_hi       = (in_pa_q < in_pb_q) ? in_pb_q : in_pa_q;
    sum_sel.cls   = {{(CLS_MAX_W-2){1'b0}}, in_cls_q};
    sum_sel.valid = 1'b0;
    sum_sel.slot  = '0;
    case (in_kind_q)
      READ_CLASS_TOTAL: begin
        sum_sel.valid = cls_ok;
      end
      READ_SINGLE_SUM: begin
        sum_sel.valid = cls_ok && (32'(in_pa_q) < NUM_PREDICATES);
        sum_sel.slot  = SLOT_MAX_W'(1 + 32'(in_pa_q));
      end
      READ_PAIR_SUM: begin
        sum_sel.valid = cls_ok && (32'(pair_hi) < NUM_PREDICATES);
        sum_sel.slot  = SLOT_MAX_W'(1 + NUM_PREDICATES +
                        pair_slot(32'(pair_lo), 32'(pair_hi), NUM_PREDICATES));
      end
      default: begin
        sum_sel.valid = 1'b0;
      end
    endcase
  end

  wpc_accum_bank #(
    .NUM_PREDICATES (NUM_PREDICATES),
    .NUM_CLASSES    (NUM_CLASSES)
  ) u_accum_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (accum_op),
    .sel_i     (sum_sel),
    .clip_o    (add_clip),
    .rd_sum_o  (rd_sum),
    .rd_mark_o (rd_mark)
  );

  // Result fields by operation.
  always_comb begin
    out_sum_d  = '0;
    out_hits_d = '0;
    out_sat_d  = 1'b0;
    case (in_func_q)
      FUNC_ADD_WEIGHT: begin
        out_hits_d = hits;
        out_sat_d  = add_clip;
      end
      FUNC_READ_SUM: begin
        out_sum_d = rd_sum;
        out_sat_d = rd_mark;
      end
      default: begin
        out_sat_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sum_q  <= out_sum_d;
      out_hits_q <= out_hits_d;
      out_sat_q  <= out_sat_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_hits_q, out_sum_q};
  assign m_axis_tuser  = out_sat_q;

endmodule

FILE: design/wpc_feature_store.sv
// ----------------------------------------------------------------------------
// Feature store
// Row memory of Q8.8 feature values plus one tracked copy per predicate.
// ----------------------------------------------------------------------------
module wpc_feature_store #(
  parameter int NUM_FEATURES   = 16,
  parameter int NUM_PREDICATES = 4
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  wpc_pkg::cfg_feat_t                           cfg_feat_i,
  input  logic [wpc_pkg::PRED_REGS-1:0][wpc_pkg::FEAT_REG_W-1:0] pred_feat_i,
  input  logic                                         wr_en_i,
  input  logic [wpc_pkg::FEAT_REG_W-1:0]               wr_idx_i,
  input  logic signed [wpc_pkg::VAL_W-1:0]             wr_val_i,
  output logic signed [wpc_pkg::VAL_W-1:0]             pred_val_o [NUM_PREDICATES],
  output logic [NUM_PREDICATES-1:0]                    pred_ok_o
);
  import wpc_pkg::*;

  localparam int FIDX_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

  logic signed [VAL_W-1:0] row_mem [NUM_FEATURES];
  logic signed [VAL_W-1:0] pred_val_q [NUM_PREDICATES];
  logic [NUM_PREDICATES-1:0] pred_ok_q, pred_ok_d;
  logic [7:0] wr_idx_ext, cfg_feat_ext;
  logic wr_ok, cfg_ok;

  assign wr_idx_ext   = {{(8-FEAT_REG_W){1'b0}}, wr_idx_i};
  assign cfg_feat_ext = {{(8-FEAT_REG_W){1'b0}}, cfg_feat_i.feat};
  assign wr_ok  = wr_en_i && (32'(wr_idx_ext) < NUM_FEATURES);
  assign cfg_ok = 32'(cfg_feat_ext) < NUM_FEATURES;

  // A predicate keeps its own copy of the feature it tests. It is refreshed
  // from the memory when its feature select changes, and snoops every write.
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      row_mem[wr_idx_ext[FIDX_W-1:0]] <= wr_val_i;
    end
    for (int p = 0; p < NUM_PREDICATES; p++) begin
      if (cfg_feat_i.we && (32'(cfg_feat_i.pred) == p)) begin
        pred_val_q[p] <= row_mem[cfg_feat_ext[FIDX_W-1:0]];
      end else if (wr_ok && (pred_feat_i[p] == wr_idx_i)) begin
        pred_val_q[p] <= wr_val_i;
      end
    end
  end

  always_comb begin
    pred_ok_d = pred_ok_q;
    for (int p = 0; p < NUM_PREDICATES; p++) begin
      if (cfg_feat_i.we && (32'(cfg_feat_i.pred) == p)) begin
        pred_ok_d[p] = cfg_ok;
      end
    end
  end

  // Feature selects reset to zero, which is always inside the row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_ok_q <= '1;
    end else begin
      pred_ok_q <= pred_ok_d;
    end
  end

  assign pred_val_o = pred_val_q;
  assign pred_ok_o  = pred_ok_q;

endmodule

FILE: design/wpc_accum_bank.sv
// ----------------------------------------------------------------------------
// Accumulator bank
// Per class saturating sums with sticky clip marks, updated in parallel.
// ----------------------------------------------------------------------------
module wpc_accum_bank #(
  parameter int NUM_PREDICATES = 4,
  parameter int NUM_CLASSES    = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wpc_pkg::accum_op_t               op_i,
  input  wpc_pkg::sum_sel_t                sel_i,
  output logic                             clip_o,
  output logic signed [wpc_pkg::SUM_W-1:0] rd_sum_o,
  output logic                             rd_mark_o
);
  import wpc_pkg::*;

  localparam int NPAIRS = NUM_PREDICATES * (NUM_PREDICATES + 1) / 2;
  localparam int STRIDE = 1 + NUM_PREDICATES + NPAIRS;
  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SLOT_W = $clog2(STRIDE);
  localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};

  logic signed [SUM_W-1:0] sum_q [NUM_CLASSES][STRIDE];
  logic                    mark_q [NUM_CLASSES][STRIDE];
  logic signed [SUM_W-1:0] new_sum [STRIDE];
  logic [STRIDE-1:0]       slot_en, slot_clip;
  logic signed [SUM_W:0]   raw;
  logic [CLS_W-1:0]        cls;
  logic [CLS_W-1:0]        rd_cls;
  logic [SLOT_W-1:0]       rd_slot;

  assign cls     = op_i.cls[CLS_W-1:0];
  assign rd_cls  = sel_i.cls[CLS_W-1:0];
  assign rd_slot = sel_i.slot[SLOT_W-1:0];

  // Which sums take the weight: the total always, a single sum when its
  // predicate holds, a pair sum when both of its predicates hold.
  always_comb begin
    slot_en    = '0;
    slot_en[0] = 1'b1;
    for (int i = 0; i < NUM_PREDICATES; i++) begin
      slot_en[1+i] = op_i.hits[i];
      for (int j = i; j < NUM_PREDICATES; j++) begin
        slot_en[1+NUM_PREDICATES+pair_slot(i, j, NUM_PREDICATES)] =
          op_i.hits[i] & op_i.hits[j];
      end
    end
  end

  always_comb begin
    raw = '0;
    for (int k = 0; k < STRIDE; k++) begin
      raw = {sum_q[cls][k][SUM_W-1], sum_q[cls][k]} +
            {{(SUM_W+1-VAL_W){op_i.weight[VAL_W-1]}}, op_i.weight};
      if (raw > SUM_MAX) begin
        new_sum[k]   = SUM_MAX[SUM_W-1:0];
        slot_clip[k] = 1'b1;
      end else if (raw < SUM_MIN) begin
        new_sum[k]   = SUM_MIN[SUM_W-1:0];
        slot_clip[k] = 1'b1;
      end else begin
        new_sum[k]   = raw[SUM_W-1:0];
        slot_clip[k] = 1'b0;
      end
    end
  end

  assign clip_o = op_i.add && |(slot_en & slot_clip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        for (int k = 0; k < STRIDE; k++) begin
          sum_q[c][k]  <= '0;
          mark_q[c][k] <= 1'b0;
        end
      end
    end else if (op_i.clr) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        for (int k = 0; k < STRIDE; k++) begin
          sum_q[c][k]  <= '0;
          mark_q[c][k] <= 1'b0;
        end
      end
    end else if (op_i.add) begin
      for (int k = 0; k < STRIDE; k++) begin
        if (slot_en[k]) begin
          sum_q[cls][k] <= new_sum[k];
          if (slot_clip[k]) begin
            mark_q[cls][k] <= 1'b1;
          end
        end
      end
    end
  end

  assign rd_sum_o  = sel_i.valid ? sum_q[rd_cls][rd_slot] : '0;
  assign rd_mark_o = sel_i.valid && mark_q[rd_cls][rd_slot];

endmodule
